// ===== hw/rtl/dqrm_pkg.sv =====
// ----------------------------------------------------------------------------
// dqrm_pkg
// Shared types and constants of the dns query/response matcher.
// ----------------------------------------------------------------------------
package dqrm_pkg;

    // default ring size
    localparam int TABLE_ENTRIES_DEF = 64;

    // widths fixed by the packet fields
    localparam int ADDR_W   = 32;
    localparam int QID_W    = 16;
    localparam int TIME_W   = 64;
    localparam int ANS_W    = 16;
    localparam int RCODE_W  = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int LAT_W    = 32;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_QUERY_NEW      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUERY_REPLACED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MATCHED        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN        = 2'd3;

    // packet kinds
    localparam logic CMD_QUERY    = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    // one stored query
    typedef struct packed {
        logic [ADDR_W-1:0] client;
        logic [ADDR_W-1:0] server;
        logic [QID_W-1:0]  qid;
        logic [TIME_W-1:0] send_time;
    } entry_t;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_LATENCY
    } ctrl_state_t;

endpackage

// ===== hw/rtl/dqrm_table.sv =====
// ----------------------------------------------------------------------------
// dqrm_table
// Query ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dqrm_table
    import dqrm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dqrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqrm_ctrl
// Ring pointer, newest-first search sequencer and result registers.
// ----------------------------------------------------------------------------
module dqrm_ctrl
    import dqrm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [ADDR_W-1:0]   src_addr,
    input  logic [ADDR_W-1:0]   dst_addr,
    input  logic [QID_W-1:0]    query_id,
    input  logic [TIME_W-1:0]   timestamp_us,
    input  logic [ANS_W-1:0]    answer_count,
    input  logic [RCODE_W-1:0]  rcode,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot,
    output logic [LAT_W-1:0]    latency_us,
    output logic                answer_good,
    // table ports
    output logic                tbl_we,
    output logic [IDX_W-1:0]    tbl_waddr,
    output entry_t              tbl_wdata,
    output logic [IDX_W-1:0]    tbl_raddr,
    input  entry_t              tbl_rdata
);

    localparam int               CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(TABLE_ENTRIES - 1);

    // control state
    ctrl_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic                full_reg, full_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic                done_reg, done_next;

    // payload
    logic [ADDR_W-1:0]   key_src_reg, key_src_next;
    logic [ADDR_W-1:0]   key_dst_reg, key_dst_next;
    logic [QID_W-1:0]    key_qid_reg, key_qid_next;
    logic [TIME_W-1:0]   key_ts_reg, key_ts_next;
    logic                key_good_reg, key_good_next;
    logic [TIME_W-1:0]   send_reg, send_next;
    logic [IDX_W-1:0]    midx_reg, midx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [LAT_W-1:0]    lat_reg, lat_next;
    logic                good_reg, good_next;

    logic                accept;
    logic [CNT_W-1:0]    fill_count;
    logic                hit;
    logic [TIME_W:0]     diff;

    // ring step back by one
    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        r = (a == '0) ? LAST : a - 1'b1;
        return r;
    endfunction

    // low bits of an index for the slot field
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] a);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, a};
        return ext[SLOT_W-1:0];
    endfunction

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign fill_count = full_reg ? CNT_W'(TABLE_ENTRIES) : {1'b0, wp_reg};

    // entry compare, client against destination, server against source and query id
    assign hit = (tbl_rdata.client == key_dst_reg) &&
                 (tbl_rdata.server == key_src_reg) &&
                 (tbl_rdata.qid == key_qid_reg);

    // table access
    assign tbl_we    = accept && (command == CMD_QUERY);
    assign tbl_waddr = wp_reg;
    assign tbl_wdata = '{client: src_addr, server: dst_addr, qid: query_id,
                         send_time: timestamp_us};
    assign tbl_raddr = (state_reg == S_IDLE) ? prev_idx(wp_reg) : prev_idx(cur_reg);

    // latency with borrow
    assign diff = {1'b0, key_ts_reg} - {1'b0, send_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == CMD_RESPONSE) && (fill_count != '0))
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    state_next = S_LATENCY;
                end
                else if (remain_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LATENCY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result words
    always_comb
    begin
        wp_next       = wp_reg;
        full_next     = full_reg;
        cur_next      = cur_reg;
        remain_next   = remain_reg;
        done_next     = 1'b0;
        key_src_next  = key_src_reg;
        key_dst_next  = key_dst_reg;
        key_qid_next  = key_qid_reg;
        key_ts_next   = key_ts_reg;
        key_good_next = key_good_reg;
        send_next     = send_reg;
        midx_next     = midx_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        lat_next      = lat_reg;
        good_next     = good_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == CMD_QUERY))
                begin
                    // store query at the ring pointer
                    done_next   = 1'b1;
                    status_next = full_reg ? ST_QUERY_REPLACED : ST_QUERY_NEW;
                    slot_next   = slot_of(wp_reg);
                    lat_next    = '0;
                    good_next   = 1'b0;
                    if (wp_reg == LAST)
                    begin
                        wp_next   = '0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        wp_next = wp_reg + 1'b1;
                    end
                end
                else if (accept)
                begin
                    key_src_next  = src_addr;
                    key_dst_next  = dst_addr;
                    key_qid_next  = query_id;
                    key_ts_next   = timestamp_us;
                    key_good_next = (answer_count != '0) && (rcode == '0);
                    cur_next      = prev_idx(wp_reg);
                    remain_next   = fill_count - 1'b1;
                    if (fill_count == '0)
                    begin
                        // empty table
                        done_next   = 1'b1;
                        status_next = ST_UNKNOWN;
                        slot_next   = '0;
                        lat_next    = '0;
                        good_next   = 1'b0;
                    end
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    send_next = tbl_rdata.send_time;
                    midx_next = cur_reg;
                end
                else if (remain_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_UNKNOWN;
                    slot_next   = '0;
                    lat_next    = '0;
                    good_next   = 1'b0;
                end
                else
                begin
                    cur_next    = prev_idx(cur_reg);
                    remain_next = remain_reg - 1'b1;
                end
            end
            S_LATENCY:
            begin
                done_next   = 1'b1;
                status_next = ST_MATCHED;
                slot_next   = slot_of(midx_reg);
                good_next   = key_good_reg;
                if (diff[TIME_W])
                begin
                    lat_next = '0;
                end
                else if (|diff[TIME_W-1:LAT_W])
                begin
                    lat_next = '1;
                end
                else
                begin
                    lat_next = diff[LAT_W-1:0];
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            full_reg   <= 1'b0;
            cur_reg    <= '0;
            remain_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            full_reg   <= full_next;
            cur_reg    <= cur_next;
            remain_reg <= remain_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_src_reg  <= key_src_next;
        key_dst_reg  <= key_dst_next;
        key_qid_reg  <= key_qid_next;
        key_ts_reg   <= key_ts_next;
        key_good_reg <= key_good_next;
        send_reg     <= send_next;
        midx_reg     <= midx_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        lat_reg      <= lat_next;
        good_reg     <= good_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign latency_us  = lat_reg;
    assign answer_good = good_reg;

endmodule

// ===== hw/rtl/dns_query_response_matcher.sv =====
// ----------------------------------------------------------------------------
// dns_query_response_matcher
// Stores dns queries in a ring and matches responses, newest first.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake           word
// input     in         start && !busy      command, addresses, id, time, counts
// result    out        done (one cycle)    status, slot, latency_us, answer_good
//
// a query is written as it is accepted; its result is registered and appears
// in the next cycle, and the next word may be started at once
// a response reads one ring entry per cycle from the table memory, newest
// first: a hit passes through S_SEARCH and S_LATENCY to the registered result,
// a miss returns to idle after the last of the stored entries
// reset clears the ring pointer and fill flag; no clearing pass is needed
// the receiver cannot stall, so a result is never held back
//
module dns_query_response_matcher
    import dqrm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [ADDR_W-1:0]   src_addr,
    input  logic [ADDR_W-1:0]   dst_addr,
    input  logic [QID_W-1:0]    query_id,
    input  logic [TIME_W-1:0]   timestamp_us,
    input  logic [ANS_W-1:0]    answer_count,
    input  logic [RCODE_W-1:0]  rcode,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot,
    output logic [LAT_W-1:0]    latency_us,
    output logic                answer_good
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    entry_t           tbl_wdata;
    logic [IDX_W-1:0] tbl_raddr;
    entry_t           tbl_rdata;

    // query ring memory
    dqrm_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // sequencer
    dqrm_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .query_id     (query_id),
        .timestamp_us (timestamp_us),
        .answer_count (answer_count),
        .rcode        (rcode),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .latency_us   (latency_us),
        .answer_good  (answer_good),
        .tbl_we       (tbl_we),
        .tbl_waddr    (tbl_waddr),
        .tbl_wdata    (tbl_wdata),
        .tbl_raddr    (tbl_raddr),
        .tbl_rdata    (tbl_rdata)
    );

`ifndef SYNTHESIS
    // a query word gives a stored status in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_QUERY) |=>
            done && ((status == ST_QUERY_NEW) || (status == ST_QUERY_REPLACED)))
        else $error("query word without stored result");

    // a response word either starts a search or is answered at once
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_RESPONSE) |=> busy || done)
        else $error("response word dropped");

    // results only appear once the sequencer is back in idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still searching");

    // an unknown response carries no slot, latency or good flag
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_UNKNOWN) |->
            (slot == '0) && (latency_us == '0) && !answer_good)
        else $error("unknown response with payload");
`endif

endmodule

// ===== tb/dns_query_response_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// dns_query_response_matcher_tb
// Self-checking bench for the dns query/response matcher. Packet words go in
// through the start/busy handshake. A local copy of the query ring predicts
// status, slot, latency and answer flag for every accepted word, and each
// done strobe is checked against the oldest prediction. A short directed pass
// covers the field extremes and the corner cases. Then mostly well-formed
// query/response traffic follows, with some noise, sent in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_query_response_matcher_tb;
    import dqrm_pkg::*;

    localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int RANDOM_WORDS   = 2000;
    localparam int WATCHDOG_LIMIT = 8 * (TABLE_ENTRIES + 2) + 200;
    localparam int CLIENT_POOL    = 8;
    localparam int SERVER_POOL    = 4;

    // one parsed packet as sent to the block
    typedef struct packed {
        logic                command;
        logic [ADDR_W-1:0]   src;
        logic [ADDR_W-1:0]   dst;
        logic [QID_W-1:0]    qid;
        logic [TIME_W-1:0]   ts;
        logic [ANS_W-1:0]    ans;
        logic [RCODE_W-1:0]  rcode;
    } dns_word_t;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [LAT_W-1:0]    latency;
        logic                good;
    } dns_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                command;
    logic [ADDR_W-1:0]   src_addr;
    logic [ADDR_W-1:0]   dst_addr;
    logic [QID_W-1:0]    query_id;
    logic [TIME_W-1:0]   timestamp_us;
    logic [ANS_W-1:0]    answer_count;
    logic [RCODE_W-1:0]  rcode;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [LAT_W-1:0]    latency_us;
    logic                answer_good;

    // local copy of the query ring
    logic [ADDR_W-1:0]   ring_client [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   ring_server [TABLE_ENTRIES];
    logic [QID_W-1:0]    ring_qid    [TABLE_ENTRIES];
    logic [TIME_W-1:0]   ring_sent   [TABLE_ENTRIES];
    bit                  ring_used   [TABLE_ENTRIES];
    int                  ring_ptr;

    dns_result_t         pending_results[$];

    // traffic shaping for the random part
    logic [ADDR_W-1:0]   client_pool [CLIENT_POOL];
    logic [ADDR_W-1:0]   server_pool [SERVER_POOL];
    logic [TIME_W-1:0]   wire_time_us;

    int fail_count;
    int idle_cycles;
    int n_stored;
    int n_replaced;
    int n_matched;
    int n_unknown;

    dns_query_response_matcher #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .query_id     (query_id),
        .timestamp_us (timestamp_us),
        .answer_count (answer_count),
        .rcode        (rcode),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .latency_us   (latency_us),
        .answer_good  (answer_good)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // predict the result of one packet and update the local ring
    function automatic dns_result_t track_packet(input dns_word_t w);
        dns_result_t      r;
        int               idx;
        logic [TIME_W-1:0] diff;
        r = '0;
        if (w.command == CMD_QUERY)
        begin
            r.status = ring_used[ring_ptr] ? ST_QUERY_REPLACED : ST_QUERY_NEW;
            r.slot   = SLOT_W'(ring_ptr);
            ring_client[ring_ptr] = w.src;
            ring_server[ring_ptr] = w.dst;
            ring_qid[ring_ptr]    = w.qid;
            ring_sent[ring_ptr]   = w.ts;
            ring_used[ring_ptr]   = 1'b1;
            ring_ptr = (ring_ptr + 1) % TABLE_ENTRIES;
            return r;
        end
        r.status = ST_UNKNOWN;
        // newest entry first
        for (int k = 1; k <= TABLE_ENTRIES; k++)
        begin
            idx = (ring_ptr + TABLE_ENTRIES - k) % TABLE_ENTRIES;
            if (ring_used[idx] && ring_client[idx] == w.dst &&
                ring_server[idx] == w.src && ring_qid[idx] == w.qid)
            begin
                r.status = ST_MATCHED;
                r.slot   = SLOT_W'(idx);
                r.good   = (w.ans != '0) && (w.rcode == '0);
                if (w.ts > ring_sent[idx])
                begin
                    diff      = w.ts - ring_sent[idx];
                    r.latency = (diff > 64'h0000_0000_FFFF_FFFF) ? '1 : diff[LAT_W-1:0];
                end
                return r;
            end
        end
        return r;
    endfunction

    // print one mismatch and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // present one word and wait until the block takes it; start stays high
    task automatic send_word(input dns_word_t w);
        start        <= 1'b1;
        command      <= w.command;
        src_addr     <= w.src;
        dst_addr     <= w.dst;
        query_id     <= w.qid;
        timestamp_us <= w.ts;
        answer_count <= w.ans;
        rcode        <= w.rcode;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(track_packet(w));
    endtask

    // sender gap
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic dns_word_t query_word(input logic [ADDR_W-1:0] client,
                                             input logic [ADDR_W-1:0] server,
                                             input logic [QID_W-1:0] qid,
                                             input logic [TIME_W-1:0] ts);
        dns_word_t w;
        w.command = CMD_QUERY;
        w.src     = client;
        w.dst     = server;
        w.qid     = qid;
        w.ts      = ts;
        w.ans     = ANS_W'($urandom);
        w.rcode   = RCODE_W'($urandom);
        return w;
    endfunction

    function automatic dns_word_t response_word(input logic [ADDR_W-1:0] client,
                                                input logic [ADDR_W-1:0] server,
                                                input logic [QID_W-1:0] qid,
                                                input logic [TIME_W-1:0] ts,
                                                input logic [ANS_W-1:0] ans,
                                                input logic [RCODE_W-1:0] rc);
        dns_word_t w;
        w.command = CMD_RESPONSE;
        w.src     = server;
        w.dst     = client;
        w.qid     = qid;
        w.ts      = ts;
        w.ans     = ans;
        w.rcode   = rc;
        return w;
    endfunction

    // field extremes and corner cases
    task automatic test_directed();
        logic [ADDR_W-1:0] cli;
        logic [ADDR_W-1:0] srv;
        cli = 32'hC0A8_0001;
        srv = 32'h0808_0808;
        // response into an empty table
        send_word(response_word('0, '0, '0, '0, '1, '0));
        send_word(query_word('0, '0, '0, '0));
        send_word(query_word('1, '1, '1, 64'hFFFF_FFFF_0000_0000));
        // zero latency, full answer count
        send_word(response_word('0, '0, '0, '0, '1, '0));
        // repeat response without answers
        send_word(response_word('0, '0, '0, 64'd5, '0, '0));
        // error rcode with answers
        hold_off(3);
        send_word(response_word('0, '0, '0, 64'd9, 16'd1, '1));
        // response stamped before the query
        send_word(response_word('1, '1, '1, 64'hFFFF_FFFE_FFFF_FFFF, 16'd1, '0));
        // largest difference that still fits
        send_word(response_word('1, '1, '1, '1, 16'd1, 4'd1));
        // saturating difference
        send_word(query_word(cli, srv, 16'h1234, 64'd0));
        send_word(response_word(cli, srv, 16'h1234, 64'h0000_0001_0000_0000, 16'd2, '0));
        send_word(response_word(cli, srv, 16'h1234, '1, 16'd2, '0));
        // two queries with one key, newest wins
        send_word(query_word(cli, srv, 16'hBEEF, 64'd1000));
        send_word(query_word(srv, cli, 16'hBEEF, 64'd1500));
        send_word(query_word(cli, srv, 16'hBEEF, 64'd2000));
        hold_off(1);
        send_word(response_word(cli, srv, 16'hBEEF, 64'd2600, 16'h8000, '0));
        // addresses not swapped
        send_word(response_word(srv, cli, 16'h1234, 64'd50, 16'd1, '0));
        // right pair, wrong id
        send_word(response_word(cli, srv, 16'h1235, 64'd50, 16'd1, '0));
        // right pair, error rcode with zero answers, then with one answer
        send_word(response_word(cli, srv, 16'hBEEF, 64'd1999, '0, 4'hA));
        send_word(response_word(cli, srv, 16'hBEEF, 64'd3000, 16'd1, 4'h5));
    endtask

    // one random word: mostly real query/response pairs, some noise
    function automatic dns_word_t random_word();
        dns_word_t         w;
        int                pick;
        int                idx;
        logic [TIME_W-1:0] ts;
        logic [ANS_W-1:0]  ans;
        logic [RCODE_W-1:0] rc;
        pick = $urandom_range(0, 99);
        ans  = ($urandom_range(0, 3) == 0) ? '0 : ANS_W'($urandom);
        rc   = ($urandom_range(0, 9) < 7) ? '0 : RCODE_W'($urandom);
        if (pick < 45 || !ring_used[0])
        begin
            wire_time_us += TIME_W'($urandom_range(1, 5000));
            w = query_word(client_pool[$urandom_range(0, CLIENT_POOL-1)],
                           server_pool[$urandom_range(0, SERVER_POOL-1)],
                           ($urandom_range(0, 3) == 0) ? QID_W'($urandom_range(0, 3))
                                                       : QID_W'($urandom),
                           wire_time_us);
            return w;
        end
        do
            idx = $urandom_range(0, TABLE_ENTRIES-1);
        while (!ring_used[idx]);
        case ($urandom_range(0, 9))
            0:       ts = ring_sent[idx];
            1:       ts = ring_sent[idx] - TIME_W'($urandom_range(1, 100000));
            2:       ts = ring_sent[idx] + (TIME_W'($urandom_range(1, 255)) << 32)
                          + TIME_W'($urandom);
            default: ts = ring_sent[idx] + TIME_W'($urandom_range(0, 200000));
        endcase
        w = response_word(ring_client[idx], ring_server[idx], ring_qid[idx], ts, ans, rc);
        if (pick < 85)
            return w;
        // noise: random packets and broken responses
        case ($urandom_range(0, 3))
            0:
            begin
                w = response_word($urandom, $urandom, QID_W'($urandom),
                                  {$urandom, $urandom}, ans, rc);
            end
            1:       w.qid = w.qid ^ QID_W'(1 << $urandom_range(0, QID_W-1));
            2:       w.src = w.dst;
            default:
            begin
                w = query_word($urandom, $urandom, QID_W'($urandom), {$urandom, $urandom});
            end
        endcase
        return w;
    endfunction

    // long run of random traffic in bursts
    task automatic test_random_traffic();
        int burst_left;
        burst_left = 0;
        for (int i = 0; i < CLIENT_POOL; i++)
            client_pool[i] = $urandom;
        for (int i = 0; i < SERVER_POOL; i++)
            server_pool[i] = $urandom;
        wire_time_us = {1'b0, 31'($urandom), 32'($urandom)};
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (burst_left == 0)
            begin
                hold_off($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 8);
            end
            burst_left--;
            send_word(random_word());
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        dns_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing pending",
                                64'({status, slot, latency_us, answer_good}), '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
                if (slot !== want.slot)
                    report_mismatch("slot", 64'(slot), 64'(want.slot));
                if (latency_us !== want.latency)
                    report_mismatch("latency_us", 64'(latency_us), 64'(want.latency));
                if (answer_good !== want.good)
                    report_mismatch("answer_good", 64'(answer_good), 64'(want.good));
                case (want.status)
                    ST_QUERY_NEW:      n_stored++;
                    ST_QUERY_REPLACED: n_replaced++;
                    ST_MATCHED:        n_matched++;
                    default:           n_unknown++;
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        fail_count   = 0;
        n_stored     = 0;
        n_replaced   = 0;
        n_matched    = 0;
        n_unknown    = 0;
        ring_ptr     = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            ring_used[i] = 1'b0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= CMD_QUERY;
        src_addr     <= '0;
        dst_addr     <= '0;
        query_id     <= '0;
        timestamp_us <= '0;
        answer_count <= '0;
        rcode        <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();

        // drain, then let any stray result show up
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_ENTRIES + 4) @(posedge clk);

        $display("queries: %0d into free entries, %0d over the oldest entry",
                 n_stored, n_replaced);
        $display("responses: %0d matched, %0d unknown", n_matched, n_unknown);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/dqrm_pkg.sv
hw/rtl/dqrm_table.sv
hw/rtl/dqrm_ctrl.sv
hw/rtl/dns_query_response_matcher.sv
tb/dns_query_response_matcher_tb.sv
